// ----- rtl/lpl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared widths and codes of the lane polyline locator.
// ----------------------------------------------------------------------------
package lpl_pkg;

  localparam int unsigned COORD_W   = 24;   // signed coordinate
  localparam int unsigned MAG_W     = 25;   // magnitude of a coordinate difference
  localparam int unsigned IDX_W     = 10;   // node index field
  localparam int unsigned NODE_W    = 11;   // signed reported node
  localparam int unsigned Q_W       = 32;   // Q24.8 results
  localparam int unsigned SQ_W      = 52;   // squared distances and lengths
  localparam int unsigned T_W       = 32;   // projection parameter, Q0.32
  localparam int unsigned RAD_W     = 64;   // square root radicand
  localparam int unsigned ROOT_W    = 32;   // square root result
  localparam int unsigned MSEG_W    = 16;   // minimum segment length register
  localparam int unsigned MAX_NODES = 1024;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic OP_VEHICLE = 1'b0;
  localparam logic OP_POINT   = 1'b1;

endpackage

// ----- rtl/lpl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_div
// Restoring divider, one quotient bit per cycle, for dividend < divisor.
// ----------------------------------------------------------------------------
module lpl_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpl_pkg::SQ_W-1:0]   dividend,
  input  logic [lpl_pkg::SQ_W-1:0]   divisor,
  output logic                       done,
  output logic [lpl_pkg::T_W-1:0]    quotient
);

  localparam int unsigned CNT_W = $clog2(lpl_pkg::T_W + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [lpl_pkg::SQ_W:0]     rem_r, rem_nxt;
  logic [lpl_pkg::SQ_W-1:0]   dvs_r, dvs_nxt;
  logic [lpl_pkg::T_W-1:0]    quo_r, quo_nxt;
  logic [lpl_pkg::SQ_W:0]     rem_sh;
  logic                       ge;

  assign rem_sh = {rem_r[lpl_pkg::SQ_W-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(lpl_pkg::T_W);
      rem_nxt  = {1'b0, dividend};
      dvs_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[lpl_pkg::T_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/lpl_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_sqrt
// Integer square root, two radicand bits per cycle, floor result.
// ----------------------------------------------------------------------------
module lpl_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpl_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [lpl_pkg::ROOT_W-1:0] root
);

  localparam int unsigned CNT_W = $clog2(lpl_pkg::ROOT_W + 1);
  localparam int unsigned REM_W = lpl_pkg::ROOT_W + 4;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [lpl_pkg::RAD_W-1:0]   rad_r, rad_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [lpl_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [REM_W-1:0]            rem_sh;
  logic [REM_W-1:0]            trial;
  logic                        ge;

  // remainder never exceeds twice the root, so its top two bits are spare
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[lpl_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(lpl_pkg::ROOT_W);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[lpl_pkg::RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[lpl_pkg::ROOT_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/lane_polyline_locator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_polyline_locator_top
// Locates a vehicle against a streamed lane graph and reports offset and
// arc distance along the nearest lane node.
// ----------------------------------------------------------------------------
// Items are handled one at a time; in_tready is high only while the
// sequencer is idle. A vehicle position beat only updates the vehicle
// position. A point that opens a node computes three squares on the shared
// 32x32 multiplier; a point with a bad node index goes straight to the
// bookkeeping step. A point that closes a segment also computes the squared
// length and dot product on the shared multiplier, a restoring division
// for the projection parameter, the per-axis offsets, and two square roots
// (offset and segment length) on one shared root unit. A last_point beat
// then loads the result register, waiting while the previous result has
// not been taken yet. The result register lets the next item enter while
// a result waits on the output.
// ----------------------------------------------------------------------------
module lane_polyline_locator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: min_segment_length
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpl_pkg::MSEG_W-1:0]     cfg_data,
  // input beats
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [23:0] coord_x, [47:24] coord_y, [71:48] coord_z, [81:72] node_index
  input  logic [lpl_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] opcode, [1] first_of_node
  input  logic [lpl_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           in_tlast,   // last_point
  // result beats
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [10:0] nearest_node, [42:11] lane_offset, [74:43] distance_along
  output logic [lpl_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned CW  = lpl_pkg::COORD_W;
  localparam int unsigned MW  = lpl_pkg::MAG_W;
  localparam int unsigned QW  = lpl_pkg::Q_W;
  localparam int unsigned SW  = lpl_pkg::SQ_W;
  localparam int unsigned DOT_W = SW + 2;
  localparam int unsigned W_W   = 36;

  typedef enum logic [3:0] {
    ST_IDLE, ST_D2, ST_LEN, ST_LIM, ST_DIV, ST_OFF,
    ST_SQO, ST_SQL, ST_PIECE, ST_UPD, ST_POST, ST_FIN
  } state_t;

  function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[QW] ? '1 : s[QW-1:0];
  endfunction

  function automatic logic [MW:0] sdiff(input logic signed [CW-1:0] a,
                                        input logic signed [CW-1:0] b);
    // returns {negative, magnitude} of a - b
    logic signed [MW-1:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return {d[MW-1], d[MW-1] ? MW'(-d) : MW'(d)};
  endfunction

  // architectural state
  state_t                    state_r, state_nxt;
  logic [1:0]                ax_r, ax_nxt;
  logic [1:0]                ph_r, ph_nxt;
  logic signed [CW-1:0]      veh_r [3];
  logic signed [CW-1:0]      veh_nxt [3];
  logic signed [CW-1:0]      prev_r [3];
  logic signed [CW-1:0]      prev_nxt [3];
  logic [lpl_pkg::MSEG_W-1:0] mseg_r, mseg_nxt;
  logic [SW-1:0]             gbest_r, gbest_nxt;
  logic signed [lpl_pkg::NODE_W-1:0] best_node_r, best_node_nxt;
  logic [SW-1:0]             nbest_r, nbest_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic [QW-1:0]             cum_r, cum_nxt;
  logic [QW-1:0]             nmin_r, nmin_nxt;
  logic [QW-1:0]             nalong_r, nalong_nxt;
  logic [QW-1:0]             rep_off_r, rep_off_nxt;
  logic [QW-1:0]             rep_along_r, rep_along_nxt;
  logic                      open_r, open_nxt;
  logic [lpl_pkg::IDX_W-1:0] open_idx_r, open_idx_nxt;
  logic                      seg_seen_r, seg_seen_nxt;
  logic                      cand_ok_r, cand_ok_nxt;
  logic [QW-1:0]             cand_off_r, cand_off_nxt;
  logic [QW-1:0]             cand_along_r, cand_along_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // per-item working registers
  logic signed [CW-1:0]      pt_r [3];
  logic signed [CW-1:0]      pt_nxt [3];
  logic                      last_r, last_nxt;
  logic                      idx_ok_r, idx_ok_nxt;
  logic [MW-1:0]             ddm_r [3];
  logic [MW-1:0]             ddm_nxt [3];
  logic [MW-1:0]             dm_r [3];
  logic [MW-1:0]             dm_nxt [3];
  logic                      dn_r [3];
  logic                      dn_nxt [3];
  logic [MW-1:0]             vm_r [3];
  logic [MW-1:0]             vm_nxt [3];
  logic                      vn_r [3];
  logic                      vn_nxt [3];
  logic [SW-1:0]             acc_r, acc_nxt;
  logic [SW-1:0]             len2_r, len2_nxt;
  logic signed [DOT_W-1:0]   dot_r, dot_nxt;
  logic [lpl_pkg::T_W-1:0]   t_r, t_nxt;
  logic                      full_r, full_nxt;
  logic [QW-1:0]             m_r, m_nxt;
  logic [63:0]               sum_r, sum_nxt;
  logic                      sat_r, sat_nxt;
  logic [QW-1:0]             off_r, off_nxt;
  logic [QW-1:0]             seglen_r, seglen_nxt;
  logic [QW-1:0]             piece_r, piece_nxt;
  logic [63:0]               prod_r;
  logic [lpl_pkg::NODE_W-1:0] out_node_r, out_node_nxt;
  logic [QW-1:0]             out_off_r, out_off_nxt;
  logic [QW-1:0]             out_along_r, out_along_nxt;

  // shared multiplier operands
  logic [31:0]               mul_a, mul_b;

  // input fields
  logic                      in_opcode, in_first;
  logic signed [CW-1:0]      in_coord [3];
  logic [lpl_pkg::IDX_W-1:0] in_idx;
  logic                      in_fire;

  // datapath terms
  logic [SW-1:0]             d2_sum;
  logic signed [DOT_W-1:0]   dot_term;
  logic                      seg_skip;
  logic [33:0]               e_w;
  logic signed [W_W-1:0]     vv_w, se_w, w_w;
  logic [W_W-1:0]            m_w;
  logic [64:0]               sq_sum;
  logic                      close_better;
  logic signed [lpl_pkg::NODE_W-1:0] fin_node;
  logic                      fin_ok;
  logic [MW:0]               dd_tmp [3];
  logic [MW:0]               d_tmp [3];
  logic [MW:0]               v_tmp [3];

  // divider and root units
  logic                      div_start, div_done;
  logic [lpl_pkg::T_W-1:0]   div_quo;
  logic                      sqrt_start, sqrt_done;
  logic [lpl_pkg::RAD_W-1:0] sqrt_rad;
  logic [lpl_pkg::ROOT_W-1:0] sqrt_root;

  assign in_opcode   = in_tuser[0];
  assign in_first    = in_tuser[1];
  assign in_coord[0] = in_tdata[CW-1:0];
  assign in_coord[1] = in_tdata[2*CW-1:CW];
  assign in_coord[2] = in_tdata[3*CW-1:2*CW];
  assign in_idx      = in_tdata[3*CW +: lpl_pkg::IDX_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  lpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dot_r[SW-1:0]),
    .divisor  (len2_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // offset root first, then segment length root
  assign sqrt_rad = (state_r == ST_SQO) ? sum_r : {len2_r[47:0], 16'b0};

  lpl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // operand selection for the shared multiplier; the product is registered in prod_r
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_D2: begin
        mul_a = 32'(ddm_r[ax_r]);
        mul_b = 32'(ddm_r[ax_r]);
      end
      ST_LEN: begin
        mul_a = (ph_r == 2'd0) ? 32'(dm_r[ax_r]) : 32'(vm_r[ax_r]);
        mul_b = 32'(dm_r[ax_r]);
      end
      ST_LIM: begin
        mul_a = 32'(mseg_r);
        mul_b = 32'(mseg_r);
      end
      ST_OFF: begin
        mul_a = (ph_r == 2'd0) ? 32'(dm_r[ax_r]) : m_r;
        mul_b = (ph_r == 2'd0) ? t_r : m_r;
      end
      ST_PIECE: begin
        mul_a = t_r;
        mul_b = seglen_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // per-axis offset from the projected point
  always_comb begin
    e_w    = full_r ? {1'b0, dm_r[ax_r], 8'b0} : prod_r[57:24];
    vv_w   = vn_r[ax_r] ? -$signed({3'b0, vm_r[ax_r], 8'b0}) : $signed({3'b0, vm_r[ax_r], 8'b0});
    se_w   = dn_r[ax_r] ? -$signed({2'b0, e_w}) : $signed({2'b0, e_w});
    w_w    = vv_w - se_w;
    m_w    = w_w[W_W-1] ? W_W'(-w_w) : W_W'(w_w);
    sq_sum = {1'b0, sum_r} + {1'b0, prod_r};
  end

  assign d2_sum   = acc_r + SW'(prod_r[48:0]);
  assign dot_term = (vn_r[ax_r] ^ dn_r[ax_r]) ? -$signed(DOT_W'(prod_r[48:0]))
                                              : $signed(DOT_W'(prod_r[48:0]));
  assign seg_skip = (len2_r == '0) || (len2_r < SW'(prod_r[31:0]));

  // closing the open node at the end of the graph
  assign close_better = open_r && (nbest_r < gbest_r);
  assign fin_node     = close_better ? $signed({1'b0, open_idx_r}) : best_node_r;
  assign fin_ok       = close_better ? (cnt_r == 2'd2) : cand_ok_r;

  assign div_start  = (state_r == ST_LIM) && (ph_r == 2'd1) && !seg_skip &&
                      !dot_r[DOT_W-1] && (dot_r != '0) &&
                      ($unsigned(dot_r) < {2'b0, len2_r});
  assign sqrt_start = (ph_r == 2'd0) &&
                      (((state_r == ST_SQO) && !sat_r) ||
                       ((state_r == ST_SQL) && (len2_r[SW-1:48] == '0)));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd_tmp[k] = sdiff(veh_r[k], in_coord[k]);
      d_tmp[k]  = sdiff(in_coord[k], prev_r[k]);
      v_tmp[k]  = sdiff(veh_r[k], prev_r[k]);
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ax_nxt         = ax_r;
    ph_nxt         = ph_r;
    veh_nxt        = veh_r;
    prev_nxt       = prev_r;
    mseg_nxt       = mseg_r;
    gbest_nxt      = gbest_r;
    best_node_nxt  = best_node_r;
    nbest_nxt      = nbest_r;
    cnt_nxt        = cnt_r;
    cum_nxt        = cum_r;
    nmin_nxt       = nmin_r;
    nalong_nxt     = nalong_r;
    rep_off_nxt    = rep_off_r;
    rep_along_nxt  = rep_along_r;
    open_nxt       = open_r;
    open_idx_nxt   = open_idx_r;
    seg_seen_nxt   = seg_seen_r;
    cand_ok_nxt    = cand_ok_r;
    cand_off_nxt   = cand_off_r;
    cand_along_nxt = cand_along_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    pt_nxt         = pt_r;
    last_nxt       = last_r;
    idx_ok_nxt     = idx_ok_r;
    ddm_nxt        = ddm_r;
    dm_nxt         = dm_r;
    dn_nxt         = dn_r;
    vm_nxt         = vm_r;
    vn_nxt         = vn_r;
    acc_nxt        = acc_r;
    len2_nxt       = len2_r;
    dot_nxt        = dot_r;
    t_nxt          = t_r;
    full_nxt       = full_r;
    m_nxt          = m_r;
    sum_nxt        = sum_r;
    sat_nxt        = sat_r;
    off_nxt        = off_r;
    seglen_nxt     = seglen_r;
    piece_nxt      = piece_r;
    out_node_nxt   = out_node_r;
    out_off_nxt    = out_off_r;
    out_along_nxt  = out_along_r;

    if (cfg_valid) begin
      mseg_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_opcode == lpl_pkg::OP_VEHICLE) begin
            veh_nxt = in_coord;
          end else begin
            pt_nxt     = in_coord;
            last_nxt   = in_tlast;
            idx_ok_nxt = 32'(in_idx) < lpl_pkg::MAX_NODES;
            for (int k = 0; k < 3; k++) begin
              ddm_nxt[k] = dd_tmp[k][MW-1:0];
              dm_nxt[k]  = d_tmp[k][MW-1:0];
              dn_nxt[k]  = d_tmp[k][MW];
              vm_nxt[k]  = v_tmp[k][MW-1:0];
              vn_nxt[k]  = v_tmp[k][MW];
            end
            ax_nxt  = '0;
            ph_nxt  = '0;
            acc_nxt = '0;
            if (32'(in_idx) < lpl_pkg::MAX_NODES) begin
              if (in_first || !open_r) begin
                // close the open node, then open a fresh one
                if (close_better) begin
                  gbest_nxt      = nbest_r;
                  best_node_nxt  = $signed({1'b0, open_idx_r});
                  cand_ok_nxt    = (cnt_r == 2'd2);
                  cand_off_nxt   = nmin_r;
                  cand_along_nxt = nalong_r;
                end
                open_nxt     = 1'b1;
                open_idx_nxt = in_idx;
                nbest_nxt    = '1;
                cnt_nxt      = '0;
                cum_nxt      = '0;
                nmin_nxt     = '1;
                nalong_nxt   = '0;
                seg_seen_nxt = 1'b0;
              end
              state_nxt = ST_D2;
            end else begin
              state_nxt = ST_POST;
            end
          end
        end
      end

      ST_D2: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          acc_nxt = d2_sum;
          ph_nxt  = 2'd0;
          if (ax_r == 2'd2) begin
            if (d2_sum < nbest_r) begin
              nbest_nxt = d2_sum;
            end
            ax_nxt   = '0;
            len2_nxt = '0;
            dot_nxt  = '0;
            state_nxt = (cnt_r != 2'd0) ? ST_LEN : ST_POST;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end
      end

      ST_LEN: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          len2_nxt = len2_r + SW'(prod_r[48:0]);
          ph_nxt   = 2'd2;
        end else begin
          dot_nxt = dot_r + dot_term;
          ph_nxt  = 2'd0;
          if (ax_r == 2'd2) begin
            ax_nxt    = '0;
            state_nxt = ST_LIM;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end
      end

      ST_LIM: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt   = 2'd0;
          ax_nxt   = '0;
          sum_nxt  = '0;
          sat_nxt  = 1'b0;
          full_nxt = 1'b0;
          t_nxt    = '0;
          if (seg_skip) begin
            state_nxt = ST_POST;
          end else if (dot_r[DOT_W-1] || (dot_r == '0)) begin
            state_nxt = ST_OFF;
          end else if ($unsigned(dot_r) >= {2'b0, len2_r}) begin
            full_nxt  = 1'b1;
            state_nxt = ST_OFF;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          t_nxt     = div_quo;
          state_nxt = ST_OFF;
        end
      end

      ST_OFF: begin
        unique case (ph_r)
          2'd0: ph_nxt = 2'd1;
          2'd1: begin
            if (m_w[W_W-1:QW] != '0) begin
              sat_nxt   = 1'b1;
              ph_nxt    = 2'd0;
              state_nxt = ST_SQO;
            end else begin
              m_nxt  = m_w[QW-1:0];
              ph_nxt = 2'd2;
            end
          end
          2'd2: ph_nxt = 2'd3;
          default: begin
            ph_nxt = 2'd0;
            if (sq_sum[64]) begin
              sat_nxt   = 1'b1;
              state_nxt = ST_SQO;
            end else begin
              sum_nxt = sq_sum[63:0];
              if (ax_r == 2'd2) begin
                state_nxt = ST_SQO;
              end else begin
                ax_nxt = ax_r + 2'd1;
              end
            end
          end
        endcase
      end

      ST_SQO: begin
        if (ph_r == 2'd0) begin
          if (sat_r) begin
            off_nxt   = '1;
            state_nxt = ST_SQL;
          end else begin
            ph_nxt = 2'd1;
          end
        end else if (sqrt_done) begin
          off_nxt   = sqrt_root;
          ph_nxt    = 2'd0;
          state_nxt = ST_SQL;
        end
      end

      ST_SQL: begin
        if (ph_r == 2'd0) begin
          if (len2_r[SW-1:48] != '0) begin
            seglen_nxt = '1;
            state_nxt  = ST_PIECE;
          end else begin
            ph_nxt = 2'd1;
          end
        end else if (sqrt_done) begin
          seglen_nxt = sqrt_root;
          ph_nxt     = 2'd0;
          state_nxt  = ST_PIECE;
        end
      end

      ST_PIECE: begin
        if (full_r) begin
          piece_nxt = seglen_r;
          state_nxt = ST_UPD;
        end else if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          piece_nxt = prod_r[63:32];
          ph_nxt    = 2'd0;
          state_nxt = ST_UPD;
        end
      end

      ST_UPD: begin
        // strict compare: the earlier segment keeps a tie
        if (!seg_seen_r || (off_r < nmin_r)) begin
          seg_seen_nxt = 1'b1;
          nmin_nxt     = off_r;
          nalong_nxt   = sat_add(cum_r, piece_r);
        end
        cum_nxt   = sat_add(cum_r, seglen_r);
        state_nxt = ST_POST;
      end

      ST_POST: begin
        if (idx_ok_r) begin
          if (cnt_r != 2'd2) begin
            cnt_nxt = cnt_r + 2'd1;
          end
          prev_nxt = pt_r;
        end
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end

      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = fin_node;
          if (!fin_node[lpl_pkg::NODE_W-1] && fin_ok) begin
            rep_off_nxt   = cand_off_r;
            rep_along_nxt = cand_along_r;
            out_off_nxt   = close_better ? nmin_r : cand_off_r;
            out_along_nxt = close_better ? nalong_r : cand_along_r;
            if (close_better) begin
              rep_off_nxt   = nmin_r;
              rep_along_nxt = nalong_r;
            end
          end else begin
            out_off_nxt   = rep_off_r;
            out_along_nxt = rep_along_r;
          end
          // clear the scan for the next graph
          gbest_nxt      = '1;
          best_node_nxt  = '1;
          cand_ok_nxt    = 1'b0;
          cand_off_nxt   = '0;
          cand_along_nxt = '0;
          open_nxt       = 1'b0;
          open_idx_nxt   = '0;
          nbest_nxt      = '1;
          cnt_nxt        = '0;
          cum_nxt        = '0;
          nmin_nxt       = '1;
          nalong_nxt     = '0;
          seg_seen_nxt   = 1'b0;
          for (int k = 0; k < 3; k++) begin
            prev_nxt[k] = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ax_r         <= '0;
      ph_r         <= '0;
      for (int k = 0; k < 3; k++) begin
        veh_r[k]  <= '0;
        prev_r[k] <= '0;
      end
      mseg_r       <= lpl_pkg::MSEG_W'(1);
      gbest_r      <= '1;
      best_node_r  <= '1;
      nbest_r      <= '1;
      cnt_r        <= '0;
      cum_r        <= '0;
      nmin_r       <= '1;
      nalong_r     <= '0;
      rep_off_r    <= '0;
      rep_along_r  <= '0;
      open_r       <= 1'b0;
      open_idx_r   <= '0;
      seg_seen_r   <= 1'b0;
      cand_ok_r    <= 1'b0;
      cand_off_r   <= '0;
      cand_along_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ax_r         <= ax_nxt;
      ph_r         <= ph_nxt;
      veh_r        <= veh_nxt;
      prev_r       <= prev_nxt;
      mseg_r       <= mseg_nxt;
      gbest_r      <= gbest_nxt;
      best_node_r  <= best_node_nxt;
      nbest_r      <= nbest_nxt;
      cnt_r        <= cnt_nxt;
      cum_r        <= cum_nxt;
      nmin_r       <= nmin_nxt;
      nalong_r     <= nalong_nxt;
      rep_off_r    <= rep_off_nxt;
      rep_along_r  <= rep_along_nxt;
      open_r       <= open_nxt;
      open_idx_r   <= open_idx_nxt;
      seg_seen_r   <= seg_seen_nxt;
      cand_ok_r    <= cand_ok_nxt;
      cand_off_r   <= cand_off_nxt;
      cand_along_r <= cand_along_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    pt_r        <= pt_nxt;
    last_r      <= last_nxt;
    idx_ok_r    <= idx_ok_nxt;
    ddm_r       <= ddm_nxt;
    dm_r        <= dm_nxt;
    dn_r        <= dn_nxt;
    vm_r        <= vm_nxt;
    vn_r        <= vn_nxt;
    acc_r       <= acc_nxt;
    len2_r      <= len2_nxt;
    dot_r       <= dot_nxt;
    t_r         <= t_nxt;
    full_r      <= full_nxt;
    m_r         <= m_nxt;
    sum_r       <= sum_nxt;
    sat_r       <= sat_nxt;
    off_r       <= off_nxt;
    seglen_r    <= seglen_nxt;
    piece_r     <= piece_nxt;
    prod_r      <= 64'(mul_a) * 64'(mul_b);
    out_node_r  <= out_node_nxt;
    out_off_r   <= out_off_nxt;
    out_along_r <= out_along_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_along_r, out_off_r, out_node_r};

  // a result appears only from the end-of-graph step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside end of graph");

  // the divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done out of turn");

  // the root unit finishes only while a root is awaited
  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (((state_r == ST_SQO) || (state_r == ST_SQL)) && (ph_r == 2'd1)))
    else $error("root done out of turn");

  // a scored segment implies a node of at least two points
  a_seg_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_seen_r && (state_r == ST_IDLE)) |-> (cnt_r == 2'd2))
    else $error("segment seen with fewer than two points");

endmodule
